FILE: rtl/bfa_pkg.sv
// Shared types and constants of the bitmap frame allocator.
package bfa_pkg;

   localparam int ADDR_W     = 48;
   localparam int CNT_IN_W   = 15;
   localparam int STAT_CNT_W = 32;

   localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 48'h00_0001_000000;

   // Request actions.
   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_FREE    = 2'd1;
   localparam logic [1:0] ACT_RESERVE = 2'd2;
   localparam logic [1:0] ACT_QUERY   = 2'd3;

   // Response status codes.
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_NO_RUN   = 2'd1;
   localparam logic [1:0] STS_BAD      = 2'd2;
   localparam logic [1:0] STS_CONFLICT = 2'd3;

   typedef struct packed {
      logic [1:0]          action;
      logic [CNT_IN_W-1:0] num_frames;
      logic [CNT_IN_W-1:0] align_step;
      logic [ADDR_W-1:0]   address;
   } req_type;

   typedef struct packed {
      logic                  ok;
      logic [1:0]            status;
      logic [ADDR_W-1:0]     result_address;
      logic [CNT_IN_W-1:0]   used_total;
      logic [CNT_IN_W-1:0]   reserved_total;
      logic [STAT_CNT_W-1:0] alloc_count;
      logic [STAT_CNT_W-1:0] free_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_MOD_WAIT,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_SCAN_BIT,
      ST_RW_RD,
      ST_RW_WAIT,
      ST_Q_RD,
      ST_Q_WAIT,
      ST_FINISH
   } fsm_state_type;

endpackage

FILE: rtl/bfa_ram.sv
// Generic simple dual-port RAM with a registered read port.
module bfa_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 512,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bfa_mod.sv
// Bit-serial remainder unit: one dividend bit per cycle.
module bfa_mod #(
   parameter int DW = 14,
   parameter int VW = 15
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [VW-1:0] remainder
);

   localparam int SW = $clog2(DW + 1);

   logic [DW-1:0] dvd_ff, dvd_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [SW-1:0] step_ff, step_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;

   // Restoring step: shift in one bit, subtract the divisor when it fits.
   always_comb begin
      trial   = {rem_ff, dvd_ff[DW-1]};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         step_in = SW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = VW'(trial - {1'b0, divisor});
         end else begin
            rem_in = VW'(trial);
         end
         dvd_in  = dvd_ff << 1;
         step_in = step_ff - SW'(1);
         if (step_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/bitmap_frame_allocator_top.sv
// Bitmap page-frame allocator with next-fit search over a used-bit map in RAM.
//
//  Channel | Ports                          | Direction | Beat carries
//  --------+--------------------------------+-----------+---------------------------
//  request | req_valid, req_ready, req_data | in        | action, count, align, addr
//  result  | rsp_valid, rsp_ready, rsp_data | out       | status, address, counters
//  csr     | csr_valid, csr_ready, csr_wdata| in        | pool_base
//
// One request is handled at a time. Allocate first computes the cursor remainder in the
// remainder unit, then scans one frame per cycle, pausing to read each map word, from the
// cursor and again from frame zero if needed, then reads and writes back each marked word.
// Free and reserve read each word to check it, then read and write each word back.
// After reset the map is cleared one word per cycle with req_ready low. A waiting result
// holds the finish step until it is taken.
module bitmap_frame_allocator_top #(
   parameter int FRAME_COUNT   = 16384,
   parameter int PAGE_SHIFT    = 12,
   parameter int MAP_WORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bfa_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bfa_pkg::rsp_type         rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [bfa_pkg::ADDR_W-1:0] csr_wdata
);

   import bfa_pkg::*;

   // Map word size must be a power of two.
   localparam int IDX_W     = $clog2(FRAME_COUNT);
   localparam int CW        = $clog2(FRAME_COUNT + 1);
   localparam int LW        = (IDX_W + 2 > CNT_IN_W + 1) ? IDX_W + 2 : CNT_IN_W + 1;
   localparam int BIT_W     = $clog2(MAP_WORD_BITS);
   localparam int MAP_WORDS = (FRAME_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int AW        = $clog2(MAP_WORDS);
   localparam int PW        = ADDR_W - PAGE_SHIFT;
   localparam logic [LW-1:0] FC_L = LW'(FRAME_COUNT);

   fsm_state_type state_ff, state_in;

   req_type                  req_ff, req_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]        pool_base_ff;
   logic [LW-1:0]            pos_ff, pos_in;
   logic [LW-1:0]            run_ff, run_in;
   logic [LW-1:0]            start_ff, start_in;
   logic [LW-1:0]            end_ff, end_in;
   logic [CNT_IN_W-1:0]      phase_ff, phase_in;
   logic                     pass_ff, pass_in;
   logic                     wr_mode_ff, wr_mode_in;
   logic                     set_ff, set_in;
   logic [1:0]               status_ff, status_in;
   logic                     ok_ff, ok_in;
   logic [MAP_WORD_BITS-1:0] word_ff, word_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic [IDX_W-1:0]         cursor_ff, cursor_in;
   logic [CW-1:0]            used_ff, used_in;
   logic [CW-1:0]            resv_ff, resv_in;
   logic [STAT_CNT_W-1:0]    alloc_ff, alloc_in;
   logic [STAT_CNT_W-1:0]    frees_ff, frees_in;

   logic                     ram_wr_en, ram_rd_en;
   logic [AW-1:0]            ram_wr_addr;
   logic [MAP_WORD_BITS-1:0] ram_wr_data, ram_rd_data;

   logic                     mod_start, mod_done;
   logic [CNT_IN_W-1:0]      mod_rem;

   logic [ADDR_W-1:0]        off;
   logic                     addr_bad, range_bad;
   logic [LW-1:0]            idx_l, cnt_l, range_end;
   logic [CNT_IN_W-1:0]      al;

   logic                     cur_bit, found;
   logic [LW-1:0]            run_n, start_n, pos_nx;
   logic [CNT_IN_W-1:0]      phase_n;

   logic [LW-1:0]            base, rem_len, next_base;
   logic [BIT_W:0]           span;
   logic [MAP_WORD_BITS-1:0] ones, mask, hit_bits;

   logic [LW-1:0]            used_add, resv_add, s_end;

   // Map storage and the remainder unit for the cursor phase.
   bfa_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_ff[BIT_W +: AW]),
      .rd_data (ram_rd_data)
   );

   bfa_mod #(
      .DW (IDX_W),
      .VW (CNT_IN_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (cursor_ff),
      .divisor   (al),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Address decode and range checks.
   always_comb begin
      off       = req_ff.address - pool_base_ff;
      addr_bad  = (req_ff.address < pool_base_ff) ||
                  (off[PAGE_SHIFT-1:0] != '0) ||
                  (off[ADDR_W-1:PAGE_SHIFT] >= PW'(FRAME_COUNT));
      idx_l     = LW'(off[ADDR_W-1:PAGE_SHIFT]);
      cnt_l     = LW'(req_ff.num_frames);
      range_end = idx_l + cnt_l;
      range_bad = (req_ff.num_frames == '0) || (range_end > FC_L);
      al        = (req_ff.align_step == '0) ? CNT_IN_W'(1) : req_ff.align_step;
   end

   // One frame of the run search.
   always_comb begin
      cur_bit = word_ff[pos_ff[BIT_W-1:0]];
      if (cur_bit) begin
         run_n = '0;
      end else if (run_ff != '0) begin
         run_n = run_ff + LW'(1);
      end else if (phase_ff == '0) begin
         run_n = LW'(1);
      end else begin
         run_n = '0;
      end
      start_n = (!cur_bit && run_ff == '0 && phase_ff == '0) ? pos_ff : start_ff;
      found   = (run_n == cnt_l);
      phase_n = ({1'b0, phase_ff} + 16'(1) == {1'b0, al}) ? '0 : phase_ff + CNT_IN_W'(1);
      pos_nx  = pos_ff + LW'(1);
   end

   // Bit mask of the range inside the current map word.
   always_comb begin
      base      = {pos_ff[LW-1:BIT_W], BIT_W'(0)};
      rem_len   = end_ff - base;
      span      = (rem_len >= LW'(MAP_WORD_BITS)) ? (BIT_W+1)'(MAP_WORD_BITS)
                                                  : rem_len[BIT_W:0];
      ones      = '1;
      mask      = (ones << pos_ff[BIT_W-1:0]) & ~(ones << span);
      hit_bits  = mask & (set_ff ? ram_rd_data : ~ram_rd_data);
      next_base = base + LW'(MAP_WORD_BITS);
   end

   // Counter updates for a successful request.
   always_comb begin
      used_add = LW'(used_ff) + cnt_l;
      resv_add = LW'(resv_ff) + cnt_l;
      s_end    = start_ff + cnt_l;
   end

   // Next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pos_in       = pos_ff;
      run_in       = run_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      phase_in     = phase_ff;
      pass_in      = pass_ff;
      wr_mode_in   = wr_mode_ff;
      set_in       = set_ff;
      status_in    = status_ff;
      ok_in        = ok_ff;
      word_in      = word_ff;
      clr_in       = clr_ff;
      cursor_in    = cursor_ff;
      used_in      = used_ff;
      resv_in      = resv_ff;
      alloc_in     = alloc_ff;
      frees_in     = frees_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pos_ff[BIT_W +: AW];
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      mod_start    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ok_in     = 1'b0;
            status_in = STS_OK;
            start_in  = idx_l;
            pos_in    = idx_l;
            end_in    = range_end;
            if (req_ff.action == ACT_ALLOC) begin
               if (req_ff.num_frames == '0) begin
                  status_in = STS_NO_RUN;
                  state_in  = ST_FINISH;
               end else begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD_WAIT;
               end
            end else if (req_ff.action == ACT_QUERY) begin
               if (addr_bad) begin
                  status_in = STS_BAD;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_Q_RD;
               end
            end else begin
               if (addr_bad || range_bad) begin
                  status_in = STS_BAD;
                  state_in  = ST_FINISH;
               end else begin
                  wr_mode_in = 1'b0;
                  set_in     = (req_ff.action == ACT_RESERVE);
                  state_in   = ST_RW_RD;
               end
            end
         end
         ST_MOD_WAIT: begin
            if (mod_done) begin
               pos_in   = LW'(cursor_ff);
               phase_in = mod_rem;
               run_in   = '0;
               pass_in  = 1'b0;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: begin
            word_in  = ram_rd_data;
            state_in = ST_SCAN_BIT;
         end
         ST_SCAN_BIT: begin
            if (found) begin
               start_in   = start_n;
               pos_in     = start_n;
               end_in     = start_n + cnt_l;
               wr_mode_in = 1'b1;
               set_in     = 1'b1;
               state_in   = ST_RW_RD;
            end else if (pos_nx == FC_L) begin
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  pos_in   = '0;
                  phase_in = '0;
                  run_in   = '0;
                  state_in = ST_SCAN_RD;
               end else begin
                  status_in = STS_NO_RUN;
                  state_in  = ST_FINISH;
               end
            end else begin
               run_in   = run_n;
               start_in = start_n;
               phase_in = phase_n;
               pos_in   = pos_nx;
               state_in = (pos_nx[BIT_W-1:0] == '0) ? ST_SCAN_RD : ST_SCAN_BIT;
            end
         end
         ST_RW_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_RW_WAIT;
         end
         ST_RW_WAIT: begin
            if (!wr_mode_ff && (hit_bits != '0)) begin
               status_in = STS_CONFLICT;
               state_in  = ST_FINISH;
            end else begin
               // Write pass sets or clears the masked bits of this word.
               if (wr_mode_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = set_ff ? (ram_rd_data | mask) : (ram_rd_data & ~mask);
               end
               if (next_base >= end_ff) begin
                  if (wr_mode_ff) begin
                     status_in = STS_OK;
                     state_in  = ST_FINISH;
                  end else begin
                     wr_mode_in = 1'b1;
                     pos_in     = start_ff;
                     state_in   = ST_RW_RD;
                  end
               end else begin
                  pos_in   = next_base;
                  state_in = ST_RW_RD;
               end
            end
         end
         ST_Q_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_Q_WAIT;
         end
         ST_Q_WAIT: begin
            ok_in    = ram_rd_data[pos_ff[BIT_W-1:0]];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               // Commit counters and build the result beat.
               rsp_in.ok             = ok_ff;
               rsp_in.status         = status_ff;
               rsp_in.result_address = req_ff.address;
               if (status_ff == STS_OK) begin
                  case (req_ff.action)
                     ACT_ALLOC: begin
                        cursor_in = (s_end >= FC_L) ? '0 : IDX_W'(s_end);
                        used_in   = (used_add > FC_L) ? CW'(FRAME_COUNT) : CW'(used_add);
                        alloc_in  = alloc_ff + STAT_CNT_W'(1);
                        rsp_in.ok = 1'b1;
                     end
                     ACT_RESERVE: begin
                        used_in   = (used_add > FC_L) ? CW'(FRAME_COUNT) : CW'(used_add);
                        resv_in   = (resv_add > FC_L) ? CW'(FRAME_COUNT) : CW'(resv_add);
                        rsp_in.ok = 1'b1;
                     end
                     ACT_FREE: begin
                        used_in   = (LW'(used_ff) >= cnt_l) ? CW'(LW'(used_ff) - cnt_l) : '0;
                        frees_in  = frees_ff + STAT_CNT_W'(1);
                        rsp_in.ok = 1'b1;
                     end
                     default: begin
                        rsp_in.ok = ok_ff;
                     end
                  endcase
               end
               if (req_ff.action == ACT_ALLOC) begin
                  rsp_in.result_address = (status_ff == STS_OK)
                     ? pool_base_ff + (ADDR_W'(start_ff) << PAGE_SHIFT) : '0;
               end
               rsp_in.used_total     = CNT_IN_W'(used_in);
               rsp_in.reserved_total = CNT_IN_W'(resv_in);
               rsp_in.alloc_count    = alloc_in;
               rsp_in.free_count     = frees_in;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         used_ff      <= '0;
         resv_ff      <= '0;
         alloc_ff     <= '0;
         frees_ff     <= '0;
         pool_base_ff <= POOL_BASE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         used_ff      <= used_in;
         resv_ff      <= resv_in;
         alloc_ff     <= alloc_in;
         frees_ff     <= frees_in;
         if (csr_valid) begin
            pool_base_ff <= csr_wdata;
         end
      end
   end

   // Payload and work registers.
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      pos_ff     <= pos_in;
      run_ff     <= run_in;
      start_ff   <= start_in;
      end_ff     <= end_in;
      phase_ff   <= phase_in;
      pass_ff    <= pass_in;
      wr_mode_ff <= wr_mode_in;
      set_ff     <= set_in;
      status_ff  <= status_in;
      ok_ff      <= ok_in;
      word_ff    <= word_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // No request is taken while the map is being cleared.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request accepted during map clear");

   // The search never writes the map.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_BIT || state_ff == ST_SCAN_WAIT) |-> !ram_wr_en)
      else $error("map write during run search");

   // A result appears only after the finish step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   // The used count never exceeds the pool.
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(FRAME_COUNT))
      else $error("used frame count above pool size");

endmodule

FILE: bench/bfa_checker.sv
// Result checker of the bitmap frame allocator: watches all channels, predicts and compares.
`timescale 1ns / 100ps

module bfa_checker #(
   parameter int FRAMES     = 16384,
   parameter int PAGE_BITS  = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  bfa_pkg::req_type           req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  bfa_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [bfa_pkg::ADDR_W-1:0] csr_wdata,
   output int                         errors,
   output int                         pending
);

   import bfa_pkg::*;

   // Shadow copy of the allocator state.
   bit                map_used [FRAMES];
   int                next_fit;
   int                used_cnt;
   int                resv_cnt;
   logic [31:0]       allocs_done;
   logic [31:0]       frees_done;
   logic [ADDR_W-1:0] base_addr;
   rsp_type           expected_rsp [$];

   function automatic int round_up(int x, int a);
      return ((x + a - 1) / a) * a;
   endfunction

   // First aligned start at or after from with cnt free frames, or -1.
   function automatic int find_free_run(int from, int cnt, int a);
      int s;
      int j;
      bit hit;
      s = round_up(from, a);
      while (s + cnt <= FRAMES) begin
         hit = 0;
         for (j = s; j < s + cnt; j++) begin
            if (map_used[j]) begin
               hit = 1;
               break;
            end
         end
         if (!hit) return s;
         s = round_up(j + 1, a);
      end
      return -1;
   endfunction

   // Frame index of a page address inside the pool, or -1.
   function automatic int frame_of(logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] off;
      if (addr < base_addr) return -1;
      off = addr - base_addr;
      if (off[PAGE_BITS-1:0] != '0) return -1;
      off = off >> PAGE_BITS;
      if (off >= FRAMES) return -1;
      return int'(off);
   endfunction

   // Applies one request to the shadow state and returns the result it causes.
   function automatic rsp_type apply_request(req_type r);
      rsp_type o;
      int      cnt;
      int      al;
      int      s;
      int      idx;
      bit      setting;
      bit      clash;
      cnt = int'(r.num_frames);
      al  = (r.align_step == 0) ? 1 : int'(r.align_step);
      o = '0;
      o.status = STS_OK;
      o.result_address = r.address;
      if (r.action == ACT_ALLOC) begin
         s = -1;
         o.result_address = '0;
         if (cnt != 0) begin
            s = find_free_run(next_fit, cnt, al);
            if (s < 0) s = find_free_run(0, cnt, al);
         end
         if (s < 0) begin
            o.status = STS_NO_RUN;
         end else begin
            for (int i = 0; i < cnt; i++) map_used[s + i] = 1;
            next_fit = s + cnt;
            if (next_fit >= FRAMES) next_fit = 0;
            used_cnt = used_cnt + cnt;
            if (used_cnt > FRAMES) used_cnt = FRAMES;
            allocs_done++;
            o.result_address = base_addr + (ADDR_W'(s) << PAGE_BITS);
            o.ok = 1'b1;
         end
      end else if (r.action == ACT_QUERY) begin
         idx = frame_of(r.address);
         if (idx < 0) o.status = STS_BAD;
         else o.ok = map_used[idx];
      end else begin
         setting = (r.action == ACT_RESERVE);
         idx = frame_of(r.address);
         if (idx < 0 || cnt == 0 || idx + cnt > FRAMES) begin
            o.status = STS_BAD;
         end else begin
            clash = 0;
            for (int i = 0; i < cnt; i++) begin
               if (map_used[idx + i] == setting) begin
                  clash = 1;
                  break;
               end
            end
            if (clash) begin
               o.status = STS_CONFLICT;
            end else begin
               for (int i = 0; i < cnt; i++) map_used[idx + i] = setting;
               if (setting) begin
                  used_cnt = used_cnt + cnt;
                  if (used_cnt > FRAMES) used_cnt = FRAMES;
                  resv_cnt = resv_cnt + cnt;
                  if (resv_cnt > FRAMES) resv_cnt = FRAMES;
               end else begin
                  used_cnt = (used_cnt >= cnt) ? used_cnt - cnt : 0;
                  frees_done++;
               end
               o.ok = 1'b1;
            end
         end
      end
      o.used_total     = CNT_IN_W'(used_cnt);
      o.reserved_total = CNT_IN_W'(resv_cnt);
      o.alloc_count    = allocs_done;
      o.free_count     = frees_done;
      return o;
   endfunction

   task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      end
   endtask

   assign pending = expected_rsp.size();

   // On each edge: register write, result beat check, then request beat prediction.
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         foreach (map_used[i]) map_used[i] = 0;
         next_fit    = 0;
         used_cnt    = 0;
         resv_cnt    = 0;
         allocs_done = '0;
         frees_done  = '0;
         base_addr   = POOL_BASE_RESET;
         expected_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) base_addr = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               errors++;
               $display("%0t: result beat with nothing expected, actual 0x%0h",
                        $time, rsp_data);
            end else begin
               e = expected_rsp.pop_front();
               compare_field("ok", e.ok, rsp_data.ok);
               compare_field("status", e.status, rsp_data.status);
               compare_field("result_address", e.result_address, rsp_data.result_address);
               compare_field("used_total", e.used_total, rsp_data.used_total);
               compare_field("reserved_total", e.reserved_total, rsp_data.reserved_total);
               compare_field("alloc_count", e.alloc_count, rsp_data.alloc_count);
               compare_field("free_count", e.free_count, rsp_data.free_count);
            end
         end
         if (req_valid && req_ready) expected_rsp.push_back(apply_request(req_data));
      end
   end

   initial errors = 0;

endmodule

FILE: bench/tb_bitmap_frame_allocator_top.sv
// Testbench top of the bitmap frame allocator: stimulus, handshakes and verdict.
`timescale 1ns / 100ps

module tb_bitmap_frame_allocator_top;
   import bfa_pkg::*;

   localparam int FRAMES      = 16384;
   localparam int PAGE_BITS   = 12;
   localparam int STALL_LIMIT = 300000;
   localparam int PHASE_ITEMS = 170;

   typedef struct {
      int idx;
      int cnt;
   } span_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [ADDR_W-1:0] csr_wdata;
   int                errors;
   int                pending;
   int                idle_cycles;
   bit                quiet;
   logic [ADDR_W-1:0] base_now;
   req_type           sent_req [$];
   span_type          live_spans [$];

   bitmap_frame_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   bfa_checker #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .errors    (errors),
      .pending   (pending)
   );

   // Clock generation.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic logic [ADDR_W-1:0] frame_addr(int idx);
      return base_now + (ADDR_W'(idx) << PAGE_BITS);
   endfunction

   function automatic req_type make_req(logic [1:0] act, int cnt, int al,
                                        logic [ADDR_W-1:0] addr);
      req_type r;
      r.action     = act;
      r.num_frames = CNT_IN_W'(cnt);
      r.align_step = CNT_IN_W'(al);
      r.address    = addr;
      return r;
   endfunction

   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 10);
   endfunction

   // Sends one request beat; valid stays high across back-to-back beats.
   task automatic send_req(req_type r);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      sent_req.push_back(r);
   endtask

   // Writes the pool base once the block has drained.
   task automatic write_base(logic [ADDR_W-1:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending == 0);
      repeat (64) @(posedge clock);
      @(negedge clock);
      csr_wdata = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      base_now  = value;
   endtask

   // Draws one random request, mostly well-formed against the spans in use.
   function automatic req_type random_req();
      int       p;
      int       k;
      int       al;
      span_type sp;
      p = $urandom_range(0, 99);
      if (p < 35 || (p < 60 && live_spans.size() == 0)) begin
         k  = $urandom_range(0, 4);
         al = (k == 0) ? $urandom_range(0, 32767) : (1 << $urandom_range(0, 5));
         if ($urandom_range(0, 99) == 0) return make_req(ACT_ALLOC, $urandom_range(0, 32767), al,
                                                         {$urandom, $urandom});
         return make_req(ACT_ALLOC, $urandom_range(1, 32), al, {$urandom, $urandom});
      end
      if (p < 60) begin
         k  = $urandom_range(0, live_spans.size() - 1);
         sp = live_spans[k];
         live_spans.delete(k);
         // A share of frees covers only part of a span or spills past it.
         if ($urandom_range(0, 9) == 0) sp.cnt = sp.cnt + $urandom_range(0, 2) - 1;
         return make_req(ACT_FREE, sp.cnt, $urandom_range(0, 32767), frame_addr(sp.idx));
      end
      if (p < 75)
         return make_req(ACT_RESERVE, $urandom_range(1, 16), $urandom_range(0, 32767),
                         frame_addr($urandom_range(0, FRAMES - 1)));
      if (p < 88) begin
         if (live_spans.size() > 0 && $urandom_range(0, 1) == 1)
            k = live_spans[$urandom_range(0, live_spans.size() - 1)].idx;
         else
            k = $urandom_range(0, FRAMES - 1);
         return make_req(ACT_QUERY, $urandom_range(0, 32767), $urandom_range(0, 32767),
                         frame_addr(k));
      end
      // Noise: any field value, allocate excluded to avoid long failing scans.
      return make_req(2'($urandom_range(1, 3)), $urandom_range(0, 32767),
                      $urandom_range(0, 32767), {$urandom, $urandom});
   endfunction

   // Result side: random stall per beat, and tracking of spans the block handed out.
   initial begin
      int      stall;
      req_type r;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (sent_req.size() > 0) begin
            r = sent_req.pop_front();
            if (rsp_data.ok && rsp_data.status == STS_OK) begin
               if (r.action == ACT_ALLOC)
                  live_spans.push_back('{int'((rsp_data.result_address - base_now)
                                               >> PAGE_BITS), int'(r.num_frames)});
               else if (r.action == ACT_RESERVE)
                  live_spans.push_back('{int'((r.address - base_now) >> PAGE_BITS),
                                         int'(r.num_frames)});
            end
         end
         @(negedge clock);
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_bitmap_frame_allocator_top: errors");
            $finish;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      logic [ADDR_W-1:0] bases [5];
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_wdata   = '0;
      quiet       = 1'b0;
      base_now    = POOL_BASE_RESET;
      bases[0] = '0;
      bases[1] = 48'hFFFF_FFFF_F000;
      bases[2] = {$urandom, $urandom} & 48'hFFFF_FFFF_F000;
      bases[3] = 48'hFFFF_FFFF_FFFF;
      bases[4] = POOL_BASE_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part on the reset pool base.
      send_req(make_req(ACT_ALLOC, 0, 1, '0));
      send_req(make_req(ACT_ALLOC, FRAMES, 0, '0));
      send_req(make_req(ACT_QUERY, 0, 0, frame_addr(0)));
      send_req(make_req(ACT_ALLOC, 1, 1, '0));
      send_req(make_req(ACT_RESERVE, 1, 0, frame_addr(0)));
      send_req(make_req(ACT_FREE, FRAMES, 0, frame_addr(0)));
      send_req(make_req(ACT_FREE, 1, 0, frame_addr(0)));
      send_req(make_req(ACT_RESERVE, 1, 0, frame_addr(FRAMES - 1)));
      send_req(make_req(ACT_RESERVE, 2, 0, frame_addr(FRAMES - 1)));
      send_req(make_req(ACT_RESERVE, 1, 0, base_now - 48'h1000));
      send_req(make_req(ACT_QUERY, 0, 0, base_now + 48'h1));
      send_req(make_req(ACT_QUERY, 0, 0, frame_addr(FRAMES)));
      send_req(make_req(ACT_FREE, 0, 0, frame_addr(FRAMES - 1)));
      send_req(make_req(ACT_ALLOC, 3, FRAMES, '0));
      send_req(make_req(ACT_ALLOC, 1, FRAMES, '0));
      send_req(make_req(ACT_ALLOC, FRAMES, 0, '0));
      send_req(make_req(ACT_ALLOC, 32767, 32767, 48'hFFFF_FFFF_FFFF));
      send_req(make_req(ACT_FREE, 3, 0, frame_addr(0)));
      send_req(make_req(ACT_FREE, 1, 0, frame_addr(FRAMES - 1)));
      send_req(make_req(ACT_ALLOC, 7, 0, '0));
      send_req(make_req(ACT_QUERY, 0, 0, 48'hFFFF_FFFF_FFFF));
      send_req(make_req(ACT_FREE, 7, 0, frame_addr(3)));

      // Random part: a phase on the current base, then one per entry of bases, idling switched off now and then.
      for (int ph = 0; ph <= 5; ph++) begin
         if (ph > 0) write_base(bases[ph - 1]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            send_req(random_req());
         end
      end
      @(negedge clock);
      req_valid = 1'b0;
      quiet     = 1'b0;

      wait (pending == 0);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("tb_bitmap_frame_allocator_top: clean");
      else
         $display("tb_bitmap_frame_allocator_top: errors");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/bfa_mod.sv
rtl/bitmap_frame_allocator_top.sv
bench/bfa_checker.sv
bench/tb_bitmap_frame_allocator_top.sv
